>>> rtl/core/fcf_pkg.sv
// ----------------------------------------------------------------------------
// fcf_pkg
// Shared types and constants for the streaming FIR filter: configuration
// register indexes, input item kinds, controller states, controller/datapath links.
// ----------------------------------------------------------------------------
package fcf_pkg;

  localparam int MAX_TAPS_DEF   = 32;

  localparam int SAMPLE_W       = 16;
  localparam int PRODUCT_W      = 32;
  localparam int COEF_IDX_W     = 5;
  localparam int TAP_COUNT_W    = 6;
  localparam int SHIFT_W        = 5;
  localparam int CFG_DATA_W     = 6;
  localparam int CFG_IDX_W      = 1;

  localparam int TAP_COUNT_RST  = 1;
  localparam int SHIFT_RST      = 15;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_COUNT     = 1'b0,
    CFG_PRODUCT_SHIFT = 1'b1
  } cfg_reg_t;

  // Input item kinds
  typedef enum logic {
    KIND_COEF   = 1'b0,
    KIND_SAMPLE = 1'b1
  } item_kind_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } fcf_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_coef;    // write coefficient store
    logic load_sample;  // push sample into delay line, clear accumulator
    logic issue;        // read one tap pair into the MAC pipeline
    logic load_out;     // move accumulator into output register
  } fcf_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic pipe_busy;    // tap still in flight in the MAC pipeline
    logic out_blocked;  // output register holds a result not taken this cycle
  } fcf_sts_t;

endpackage

>>> rtl/core/fir_convolution_filter.sv
// ----------------------------------------------------------------------------
// fir_convolution_filter
// Streaming direct-form FIR filter, 16-bit signed samples, one shared MAC.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): in_kind = 0 loads in_value into
//    coefficient slot in_coef_index (slots at or above MAX_TAPS are dropped);
//    in_kind = 1 pushes a sample. in_block_start on a sample restarts the
//    window fill count.
//  - Output channel (out_valid/out_ready): one filtered_sample per sample
//    transaction once the window holds tap_count samples.
//  - Config port: cfg_we writes cfg_wdata into register cfg_index
//    (0 tap_count, 1 product_shift). Write only while the block is idle.
//  - A coefficient transaction, or a sample that yields no result, leaves
//    the block idle and ready for the next item. A sample that yields a
//    result issues its tap pairs in turn (effective tap count of them),
//    waits for the read/multiply/accumulate pipeline to drain and for the
//    output register to be free, then loads the output register. The input
//    reopens only after the output load, so no new item is taken while a
//    sample is still at work.
//  - Reset clears the fill count, pointers and the output valid flag; the
//    coefficient store, delay line and output data are not cleared.
//  - Receiver stall: the output register keeps the result; the next item is
//    still accepted, and the sum after it waits in the pipeline until the
//    output register frees up.
// ----------------------------------------------------------------------------
module fir_convolution_filter #(
  parameter int MAX_TAPS = fcf_pkg::MAX_TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [fcf_pkg::COEF_IDX_W-1:0]       in_coef_index,
  input  logic signed [fcf_pkg::SAMPLE_W-1:0]  in_value,
  input  logic                                 in_block_start,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [fcf_pkg::SAMPLE_W-1:0]  out_filtered_sample,
  // config port
  input  logic                                 cfg_we,
  input  logic [fcf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fcf_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW = $clog2(MAX_TAPS + 1);

  logic [fcf_pkg::TAP_COUNT_W-1:0] tap_count_r;
  logic [fcf_pkg::SHIFT_W-1:0]     product_shift_r;
  logic [TW-1:0]                   eff_taps;
  logic [AW-1:0]                   coef_addr;
  fcf_pkg::fcf_cmd_t               cmd;
  fcf_pkg::fcf_sts_t               sts;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r     <= fcf_pkg::TAP_COUNT_W'(fcf_pkg::TAP_COUNT_RST);
      product_shift_r <= fcf_pkg::SHIFT_W'(fcf_pkg::SHIFT_RST);
    end else if (cfg_we) begin
      unique case (fcf_pkg::cfg_reg_t'(cfg_index))
        fcf_pkg::CFG_TAP_COUNT:     tap_count_r     <= cfg_wdata;
        fcf_pkg::CFG_PRODUCT_SHIFT: product_shift_r <= cfg_wdata[fcf_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero taps acts as one; anything above MAX_TAPS is clamped.
  always_comb begin
    priority if (tap_count_r == '0) begin
      eff_taps = TW'(1);
    end else if (32'(tap_count_r) > MAX_TAPS) begin
      eff_taps = TW'(MAX_TAPS);
    end else begin
      eff_taps = TW'(tap_count_r);
    end
  end

  fcf_ctrl #(
    .MAX_TAPS (MAX_TAPS),
    .AW       (AW),
    .TW       (TW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_block_start (in_block_start),
    .eff_taps       (eff_taps),
    .coef_addr      (coef_addr),
    .cmd            (cmd),
    .sts            (sts)
  );

  fcf_datapath #(
    .MAX_TAPS (MAX_TAPS),
    .AW       (AW)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_coef_index       (in_coef_index),
    .in_value            (in_value),
    .coef_addr           (coef_addr),
    .product_shift       (product_shift_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_filtered_sample (out_filtered_sample)
  );

  // A new transaction never starts while taps are still in flight.
  a_accept_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !sts.pipe_busy)
    else $error("input accepted with MAC pipeline busy");

  // The sum is only handed off after the last tap is accumulated.
  a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.pipe_busy)
    else $error("result loaded before MAC pipeline drained");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid && !out_ready))
    else $error("output register overwritten while stalled");

endmodule

>>> rtl/core/fcf_ctrl.sv
// ----------------------------------------------------------------------------
// fcf_ctrl
// Sequencer for the FIR filter: input handshake, window fill count, tap
// counter and hand-off of the finished sum to the output register.
// ----------------------------------------------------------------------------
module fcf_ctrl #(
  parameter int MAX_TAPS = fcf_pkg::MAX_TAPS_DEF,
  parameter int AW       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
  parameter int TW       = $clog2(MAX_TAPS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic              in_block_start,
  input  logic [TW-1:0]     eff_taps,
  output logic [AW-1:0]     coef_addr,
  output fcf_pkg::fcf_cmd_t cmd,
  input  fcf_pkg::fcf_sts_t sts
);

  fcf_pkg::fcf_state_t state_r, state_nxt;
  logic [TW-1:0]       fill_r, fill_nxt;
  logic [TW-1:0]       tap_r, tap_nxt;
  logic                accept;

  assign accept    = in_valid && in_ready;
  assign coef_addr = AW'(tap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcf_pkg::ST_IDLE;
      fill_r  <= '0;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      tap_r   <= tap_nxt;
    end
  end

  always_comb begin
    logic [TW-1:0] fill_base;
    state_nxt = state_r;
    fill_nxt  = fill_r;
    tap_nxt   = tap_r;
    cmd       = '0;
    in_ready  = 1'b0;
    fill_base = '0;
    unique case (state_r)
      fcf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_kind == fcf_pkg::KIND_COEF) begin
            cmd.load_coef = 1'b1;
          end else begin
            cmd.load_sample = 1'b1;
            fill_base = in_block_start ? '0 : fill_r;
            fill_nxt  = (fill_base < TW'(MAX_TAPS)) ? fill_base + TW'(1) : fill_base;
            tap_nxt   = '0;
            if (fill_nxt >= eff_taps) begin
              state_nxt = fcf_pkg::ST_RUN;
            end
          end
        end
      end
      fcf_pkg::ST_RUN: begin
        cmd.issue = 1'b1;
        tap_nxt   = tap_r + TW'(1);
        if (tap_r == eff_taps - TW'(1)) begin
          state_nxt = fcf_pkg::ST_DRAIN;
        end
      end
      fcf_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy && !sts.out_blocked) begin
          cmd.load_out = 1'b1;
          state_nxt    = fcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fcf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/fcf_datapath.sv
// ----------------------------------------------------------------------------
// fcf_datapath
// Coefficient store, circular delay line, shared multiply-accumulate
// pipeline (read, multiply, shift-and-add) and the output register.
// ----------------------------------------------------------------------------
module fcf_datapath #(
  parameter int MAX_TAPS = fcf_pkg::MAX_TAPS_DEF,
  parameter int AW       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fcf_pkg::fcf_cmd_t                   cmd,
  output fcf_pkg::fcf_sts_t                   sts,
  input  logic [fcf_pkg::COEF_IDX_W-1:0]      in_coef_index,
  input  logic signed [fcf_pkg::SAMPLE_W-1:0] in_value,
  input  logic [AW-1:0]                       coef_addr,
  input  logic [fcf_pkg::SHIFT_W-1:0]         product_shift,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fcf_pkg::SAMPLE_W-1:0] out_filtered_sample
);

  logic signed [fcf_pkg::SAMPLE_W-1:0]  coef_mem  [MAX_TAPS];
  logic signed [fcf_pkg::SAMPLE_W-1:0]  delay_mem [MAX_TAPS];

  logic [AW-1:0]                        wptr_r, wptr_nxt;
  logic [AW-1:0]                        rptr_r, rptr_nxt;
  logic signed [fcf_pkg::SAMPLE_W-1:0]  coef_q_r, samp_q_r;
  logic signed [fcf_pkg::PRODUCT_W-1:0] prod_r;
  logic [fcf_pkg::PRODUCT_W-1:0]        acc_r, acc_nxt;
  logic                                 v1_r, v2_r;
  logic                                 out_valid_r, out_valid_nxt;
  logic signed [fcf_pkg::SAMPLE_W-1:0]  out_data_r;

  assign wptr_nxt = (wptr_r == AW'(MAX_TAPS - 1)) ? '0 : wptr_r + AW'(1);

  always_comb begin
    rptr_nxt = rptr_r;
    if (cmd.load_sample) begin
      rptr_nxt = wptr_nxt;
    end else if (cmd.issue) begin
      rptr_nxt = (rptr_r == '0) ? AW'(MAX_TAPS - 1) : rptr_r - AW'(1);
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.load_coef && (32'(in_coef_index) < MAX_TAPS)) begin
      coef_mem[AW'(in_coef_index)] <= in_value;
    end
    if (cmd.load_sample) begin
      delay_mem[wptr_nxt] <= in_value;
    end
    if (cmd.issue) begin
      coef_q_r <= coef_mem[coef_addr];
      samp_q_r <= delay_mem[rptr_r];
    end
  end

  // pointers and pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r      <= '0;
      rptr_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_sample) begin
        wptr_r <= wptr_nxt;
      end
      rptr_r      <= rptr_nxt;
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.load_sample) begin
      acc_nxt = '0;
    end else if (v2_r) begin
      acc_nxt = acc_r + fcf_pkg::PRODUCT_W'(prod_r >>> product_shift);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= coef_q_r * samp_q_r;
    end
    acc_r <= acc_nxt;
    if (cmd.load_out) begin
      out_data_r <= acc_r[fcf_pkg::SAMPLE_W-1:0];
    end
  end

  assign sts.pipe_busy   = v1_r || v2_r;
  assign sts.out_blocked = out_valid_r && !out_ready;

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_data_r;

endmodule

>>> bench/fir_convolution_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fir_convolution_filter_tb
// Self-checking bench for the streaming FIR filter. A queue-fed driver sends
// coefficient and sample transactions under random sender gaps. A monitor
// takes results under random receiver stalls, plus one long hold-off. Each
// result is checked against an in-bench filter model that tracks the
// coefficients, the delay line, the window fill count and the two registers.
// ----------------------------------------------------------------------------
module fir_convolution_filter_tb;
  import fcf_pkg::*;

  localparam int TAP_SLOTS       = MAX_TAPS_DEF;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int SETTLE_CYCLES   = 48;       // room for a sample still at work at the largest tap count
  localparam int HOLD_CYCLES     = 400;      // long receiver hold-off
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int MAX_REPORTS     = 10;

  // Filter settings per phase; -1 picks a random value for that phase.
  // Covers both extremes of each register, tap count zero and above the max.
  localparam int PH_TAPS [PHASES] = '{32, 0, 63, 7, 1, -1, 8, -1};
  localparam int PH_SHIFT[PHASES] = '{0, 31, 15, 10, 0, -1, 14, -1};

  typedef struct packed {
    item_kind_t                 kind;
    logic [COEF_IDX_W-1:0]      coef_index;
    logic signed [SAMPLE_W-1:0] value;
    logic                       block_start;
  } fir_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    int unsigned                stamp;    // cycle the sample transaction was accepted
  } filtered_exp_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_kind = 1'b0;
  logic [COEF_IDX_W-1:0]       in_coef_index = '0;
  logic signed [SAMPLE_W-1:0]  in_value = '0;
  logic                        in_block_start = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]  out_filtered_sample;
  logic                        cfg_we = 1'b0;
  cfg_reg_t                    cfg_index = CFG_TAP_COUNT;
  logic [CFG_DATA_W-1:0]       cfg_wdata = '0;

  fir_convolution_filter u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_coef_index       (in_coef_index),
    .in_value            (in_value),
    .in_block_start      (in_block_start),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_filtered_sample (out_filtered_sample),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  fir_item_t     pending_items[$];     // transactions waiting for the driver
  filtered_exp_t expected_samples[$];  // predicted outputs, oldest first
  fir_item_t     offered;              // transaction currently on the input port

  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          pressure_armed = 1'b0;  // set by stimulus, consumed by monitor
  bit          pressure_done = 1'b0;
  int          hold_left = 0;

  int items_accepted = 0;
  int results_checked = 0;
  int mismatch_count = 0;

  // Filter model: own copy of coefficients, delay line (0 newest) and registers
  logic signed [SAMPLE_W-1:0] coef_mem  [TAP_SLOTS];
  logic signed [SAMPLE_W-1:0] delay_hist[TAP_SLOTS];
  int                         fill_cnt = 0;
  logic [TAP_COUNT_W-1:0]     taps_reg = TAP_COUNT_W'(TAP_COUNT_RST);
  logic [SHIFT_W-1:0]         shift_reg = SHIFT_W'(SHIFT_RST);

  // tap count 0 acts as 1, anything above the store depth as the full depth
  function automatic int effective_taps(logic [TAP_COUNT_W-1:0] t);
    if (t == 0) return 1;
    if (t > TAP_SLOTS) return TAP_SLOTS;
    return int'(t);
  endfunction

  // Apply one accepted transaction; queue the filtered sample if one is due.
  function void filter_predict(fir_item_t it);
    int            eff;
    int            acc;
    int            prod;
    filtered_exp_t e;
    if (it.kind == KIND_COEF) begin
      coef_mem[it.coef_index] = it.value;  // block_start is don't-care here
      return;
    end
    for (int k = TAP_SLOTS - 1; k > 0; k--) delay_hist[k] = delay_hist[k-1];
    delay_hist[0] = it.value;
    if (it.block_start) fill_cnt = 0;
    if (fill_cnt < TAP_SLOTS) fill_cnt++;
    eff = effective_taps(taps_reg);
    if (fill_cnt < eff) return;          // window still filling
    acc = 0;
    for (int k = 0; k < eff; k++) begin
      prod = int'(coef_mem[k]) * int'(delay_hist[k]);
      acc += prod >>> shift_reg;         // arithmetic shift, sum wraps at 32 bits
    end
    e.sample = acc[SAMPLE_W-1:0];
    e.stamp  = cycle_count;
    expected_samples.push_back(e);
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, cycle counter, watchdog
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still expected",
             cycle_count, expected_samples.size());
    $display("fir_convolution_filter_tb NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: predicts on acceptance, then offers the next pending transaction.
  // Valid is held with a stable payload until the handshake completes.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        filter_predict(offered);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = pending_items.pop_front();
          in_valid       <= 1'b1;
          in_kind        <= offered.kind;
          in_coef_index  <= offered.coef_index;
          in_value       <= offered.value;
          in_block_start <= offered.block_start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transaction against the oldest expectation.
  // Expectations stamped this cycle cannot match, which keeps the check
  // independent of which always block runs first.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_samples.size() == 0 || expected_samples[0].stamp >= cycle_count) begin
          if (mismatch_count < MAX_REPORTS)
            $display("cycle %0d: unexpected result %0d", cycle_count, out_filtered_sample);
          mismatch_count++;
        end else begin
          if (out_filtered_sample !== expected_samples[0].sample) begin
            if (mismatch_count < MAX_REPORTS)
              $display("cycle %0d: filtered_sample expected %0d got %0d", cycle_count,
                       expected_samples[0].sample, out_filtered_sample);
            mismatch_count++;
          end
          void'(expected_samples.pop_front());
        end
      end
      // long hold-off once, otherwise random stalls
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (pressure_armed && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic logic signed [SAMPLE_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic fir_item_t make_item(item_kind_t kind, int idx,
                                          logic signed [SAMPLE_W-1:0] val, bit start);
    fir_item_t it;
    it.kind        = kind;
    it.coef_index  = COEF_IDX_W'(idx);
    it.value       = val;
    it.block_start = start;
    return it;
  endfunction

  // Mostly samples with random content; block starts are rare enough that the
  // window fills and results flow, occasional ones break a window mid-fill.
  function automatic fir_item_t random_item(int eff);
    if ($urandom_range(0, 9) == 0)
      return make_item(KIND_COEF, $urandom_range(0, TAP_SLOTS - 1), pick_value(),
                       1'($urandom_range(0, 1)));
    return make_item(KIND_SAMPLE, $urandom_range(0, TAP_SLOTS - 1), pick_value(),
                     $urandom_range(0, 4 * eff + 8) == 0);
  endfunction

  // Config writes only while idle: config port is driven at a clock edge.
  task automatic write_reg(cfg_reg_t idx, int data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    if (idx == CFG_TAP_COUNT) taps_reg = TAP_COUNT_W'(data);
    else                      shift_reg = SHIFT_W'(data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // All transactions sent, all results in, then room for a sample still at work
  task automatic drain_and_settle();
    while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int taps_val;
    int shift_val;
    int eff;
    foreach (coef_mem[k]) coef_mem[k] = '0;
    foreach (delay_hist[k]) delay_hist[k] = '0;
    send_idle_pct = 35;
    recv_idle_pct = 59;
    wait (rst_n);
    @(posedge clk);

    // Directed part at reset settings (one tap, shift 15). Only slot 0 is
    // read, so it is loaded first. Extreme samples against extreme
    // coefficients, including the one whose shifted sum wraps to the negative limit.
    pending_items.push_back(make_item(KIND_COEF, 0, 16'sh8000, 1'b1));
    pending_items.push_back(make_item(KIND_SAMPLE, 31, 16'sh8000, 1'b1));
    pending_items.push_back(make_item(KIND_SAMPLE, 0, 16'sh7FFF, 1'b0));
    pending_items.push_back(make_item(KIND_SAMPLE, 0, 16'sh0000, 1'b0));
    pending_items.push_back(make_item(KIND_SAMPLE, 0, 16'shFFFF, 1'b0));
    pending_items.push_back(make_item(KIND_COEF, 0, 16'sh7FFF, 1'b0));
    pending_items.push_back(make_item(KIND_SAMPLE, 0, 16'sh8000, 1'b0));
    pending_items.push_back(make_item(KIND_SAMPLE, 0, 16'sh7FFF, 1'b1));
    pending_items.push_back(make_item(KIND_SAMPLE, 0, 16'shFFFF, 1'b0));
    pending_items.push_back(make_item(KIND_COEF, 31, 16'shFFFF, 1'b0));
    pending_items.push_back(make_item(KIND_COEF, 0, 16'shFFFF, 1'b1));
    pending_items.push_back(make_item(KIND_SAMPLE, 31, 16'sh0001, 1'b0));
    pending_items.push_back(make_item(KIND_SAMPLE, 0, 16'sh8000, 1'b0));
    drain_and_settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      // idling: receiver-heavy gaps, then sender-heavy, then none
      if (ph < 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 59;
      end else if (ph < 6) begin
        send_idle_pct = 59;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      taps_val  = (PH_TAPS[ph] < 0) ? $urandom_range(0, 63) : PH_TAPS[ph];
      shift_val = (PH_SHIFT[ph] < 0) ? $urandom_range(0, 31) : PH_SHIFT[ph];
      write_reg(CFG_TAP_COUNT, taps_val);
      write_reg(CFG_PRODUCT_SHIFT, shift_val);
      eff = effective_taps(TAP_COUNT_W'(taps_val));

      // fill the whole coefficient store before the first wide window
      if (ph == 0)
        for (int k = 0; k < TAP_SLOTS; k++)
          pending_items.push_back(make_item(KIND_COEF, k, pick_value(),
                                            1'($urandom_range(0, 1))));
      // steady sender with a stalled receiver backs the block up
      if (ph == 6) pressure_armed = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        pending_items.push_back(random_item(eff));
      drain_and_settle();
    end

    $display("covered %0d input transactions and %0d filtered samples", items_accepted,
             results_checked);
    $display("over %0d filter settings incl. tap count 0/1/32/63 and shift 0/31",
             PHASES + 1);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("fir_convolution_filter_tb OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("fir_convolution_filter_tb NOT OK");
    end
    $finish;
  end

endmodule
